>>> design/cbf_pkg.sv
`default_nettype none

package cbf_pkg;

  // field widths
  localparam int KIND_W  = 2;
  localparam int HASH_W  = 32;
  localparam int HC_W    = 5;
  localparam int PS_W    = 13;
  localparam int FAULT_W = 2;
  localparam int CNTR_W  = 4;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 1;

  // serial remainder: two dividend bits per cycle over the hash word
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = HASH_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_OVER  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_UNDER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_SIZE = 1'd1;

  localparam logic [CNTR_W-1:0] COUNTER_MAX  = 4'hf;
  localparam logic [CNTR_W-1:0] COUNTER_ZERO = 4'h0;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_MOD    = 8'b0000_0100,
    ST_CALC   = 8'b0000_1000,
    ST_WRAP   = 8'b0001_0000,
    ST_READ   = 8'b0010_0000,
    ST_UPDATE = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  // one restoring remainder step against the partition size
  function automatic logic [PS_W-1:0] rem_step(input logic [PS_W-1:0] rem,
                                               input logic bit_in,
                                               input logic [PS_W-1:0] divisor);
    logic [PS_W:0] wide;
    wide = {rem, bit_in};
    if (wide >= {1'b0, divisor}) begin
      wide = wide - {1'b0, divisor};
    end
    return wide[PS_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/counting_bloom_filter.sv
`default_nettype none

// channel   direction  handshake            word contents
// in_       input      in_valid/in_ready    in_kind, in_hash_first, in_hash_second
// out_      output     out_valid/out_ready  out_present, out_fault, out_item_total
// cfg_      input      cfg_we (no wait)     cfg_index, cfg_data
//
// work per word: the serial remainder, then one read-modify-write per counter for nf counters,
//   nf = hash count clamped to MAX_HASHES, with an index wrap before each read when
//   STORE_DEPTH is not a power of two; a word touching no counter goes straight to done
// after reset a clearing pass zeroes the counter memory, with in_ready low
// one word is worked at a time; in_ready is high only while idle
// a finished result waits in the output register; the next word is accepted meanwhile
module counting_bloom_filter
  import cbf_pkg::*;
#(
  parameter int MAX_HASHES  = 16,
  parameter int STORE_DEPTH = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [KIND_W-1:0]    in_kind,
  input  wire logic [HASH_W-1:0]    in_hash_first,
  input  wire logic [HASH_W-1:0]    in_hash_second,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_present,
  output logic [FAULT_W-1:0]        out_fault,
  output logic [HASH_W-1:0]         out_item_total,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // memory address width
  localparam int AW = $clog2(STORE_DEPTH);
  localparam bit IS_POW2 = ((1 << AW) == STORE_DEPTH);
  // unwrapped index: remainder plus hash slot times partition size
  localparam int IDX_W = $clog2(MAX_HASHES) + PS_W;
  localparam int EXT_W = (IDX_W > AW) ? IDX_W : AW;
  localparam int WC_W  = 1;
  // reciprocal of the store depth, exact quotient for every IDX_W-bit index
  localparam int RS = IDX_W + AW;
  localparam int RW = IDX_W + 2;
  localparam logic [RW-1:0] RECIP_C =
    RW'(((64'd1 << RS) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH));
  localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(STORE_DEPTH);
  // hash slot counter, wide enough for the clamp limit and the register
  localparam int CW = ($clog2(MAX_HASHES + 1) > HC_W) ? $clog2(MAX_HASHES + 1) : HC_W;
  localparam logic [AW:0] DEPTH_C = (AW + 1)'(STORE_DEPTH);

  // counter memory, one read and one write port, registered read
  logic [CNTR_W-1:0] store_mem [STORE_DEPTH];
  logic [CNTR_W-1:0] rd_data_r;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [CNTR_W-1:0] mem_wdata;

  // configuration
  logic [HC_W-1:0] hash_count_r;
  logic [PS_W-1:0] partition_size_r;

  // control
  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0] item_total_r, item_total_nxt;

  // datapath
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [HASH_W-1:0]    h2_r, h2_nxt;
  logic [HASH_W-1:0]    div_a_r, div_a_nxt;
  logic [HASH_W-1:0]    div_b_r, div_b_nxt;
  logic [PS_W-1:0]      rem_a_r, rem_a_nxt;
  logic [PS_W-1:0]      rem_b_r, rem_b_nxt;
  logic [PS_W-1:0]      rem_c_r, rem_c_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [PS_W-1:0]      psize_r, psize_nxt;
  logic [CW-1:0]        nf_r, nf_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [HASH_W-1:0]    mixed_r, mixed_nxt;
  logic [PS_W-1:0]      r_r, r_nxt;
  logic [IDX_W-1:0]     base_r, base_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic [IDX_W-1:0]     wrap_src_r, wrap_src_nxt;
  logic [IDX_W-1:0]     wrap_quot_r, wrap_quot_nxt;
  logic [WC_W-1:0]      wrap_cnt_r, wrap_cnt_nxt;
  logic                 present_r, present_nxt;
  logic [FAULT_W-1:0]   fault_r, fault_nxt;
  logic                 out_present_r, out_present_nxt;
  logic [FAULT_W-1:0]   out_fault_r, out_fault_nxt;
  logic [HASH_W-1:0]    out_total_r, out_total_nxt;

  // index arithmetic helpers
  logic [HASH_W:0]   mixed_sum;
  logic [PS_W:0]     step_sum;
  logic [PS_W:0]     wrap_fix;
  logic [PS_W-1:0]   k_mod;
  logic [PS_W-1:0]   r_cur;
  logic [IDX_W-1:0]  base_cur;
  logic [IDX_W-1:0]  idx_full;
  logic [EXT_W-1:0]  idx_ext;
  logic [IDX_W+RW-1:0] wrap_prod;
  logic [IDX_W-1:0]  wrap_left;
  logic [CW-1:0]     nf_in;
  logic [CW-1:0]     hc_ext;

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_present    = out_present_r;
  assign out_fault      = out_fault_r;
  assign out_item_total = out_total_r;

  // clamp the hash count to what the design holds
  assign hc_ext = CW'(hash_count_r);
  assign nf_in  = (hc_ext > CW'(MAX_HASHES)) ? CW'(MAX_HASHES) : hc_ext;

  // next remainder of h1 + i*h2 (mod 2^32) against psize, kept incrementally:
  // add h2 mod p, and when the 32-bit sum wraps take away 2^32 mod p
  always_comb begin
    mixed_sum = {1'b0, mixed_r} + {1'b0, h2_r};
    // 2^32 mod p from (2^32 - 1) mod p
    k_mod = rem_c_r + PS_W'(1);
    if (k_mod == psize_r) begin
      k_mod = '0;
    end
    step_sum = {1'b0, r_r} + {1'b0, rem_b_r};
    if (step_sum >= {1'b0, psize_r}) begin
      step_sum = step_sum - {1'b0, psize_r};
    end
    wrap_fix = step_sum;
    if (mixed_sum[HASH_W]) begin
      if (step_sum >= {1'b0, k_mod}) begin
        wrap_fix = step_sum - {1'b0, k_mod};
      end else begin
        wrap_fix = step_sum + {1'b0, psize_r} - {1'b0, k_mod};
      end
    end
    if (hi_r == '0) begin
      r_cur    = rem_a_r;
      base_cur = '0;
    end else begin
      r_cur    = wrap_fix[PS_W-1:0];
      base_cur = base_r + IDX_W'(psize_r);
    end
    idx_full  = IDX_W'(r_cur) + base_cur;
    idx_ext   = EXT_W'(idx_full);
    // wrap modulo STORE_DEPTH: quotient by reciprocal, then take it back out
    wrap_prod = {{RW{1'b0}}, wrap_src_r} * {{IDX_W{1'b0}}, RECIP_C};
    wrap_left = wrap_src_r - wrap_quot_r * DEPTH_I;
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    out_valid_nxt   = out_valid_r;
    item_total_nxt  = item_total_r;
    kind_nxt        = kind_r;
    h2_nxt          = h2_r;
    div_a_nxt       = div_a_r;
    div_b_nxt       = div_b_r;
    rem_a_nxt       = rem_a_r;
    rem_b_nxt       = rem_b_r;
    rem_c_nxt       = rem_c_r;
    div_cnt_nxt     = div_cnt_r;
    psize_nxt       = psize_r;
    nf_nxt          = nf_r;
    hi_nxt          = hi_r;
    mixed_nxt       = mixed_r;
    r_nxt           = r_r;
    base_nxt        = base_r;
    addr_nxt        = addr_r;
    wrap_src_nxt    = wrap_src_r;
    wrap_quot_nxt   = wrap_quot_r;
    wrap_cnt_nxt    = wrap_cnt_r;
    present_nxt     = present_r;
    fault_nxt       = fault_r;
    out_present_nxt = out_present_r;
    out_fault_nxt   = out_fault_r;
    out_total_nxt   = out_total_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = addr_r;
    mem_wdata       = rd_data_r;

    // result taken by the sink
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        // zero one counter per cycle after reset
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = COUNTER_ZERO;
        if (clr_r == AW'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          h2_nxt      = in_hash_second;
          div_a_nxt   = in_hash_first;
          div_b_nxt   = in_hash_second;
          mixed_nxt   = in_hash_first;
          rem_a_nxt   = '0;
          rem_b_nxt   = '0;
          rem_c_nxt   = '0;
          div_cnt_nxt = '0;
          hi_nxt      = '0;
          nf_nxt      = nf_in;
          // partition size zero behaves as one
          psize_nxt   = (partition_size_r == '0) ? PS_W'(1) : partition_size_r;
          present_nxt = (in_kind == KIND_CHECK);
          fault_nxt   = FAULT_NONE;
          // the unused kind and a zero hash count touch no counter
          if ((in_kind != KIND_ADD && in_kind != KIND_REMOVE && in_kind != KIND_CHECK) ||
              nf_in == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        // h1 mod p, h2 mod p and (2^32 - 1) mod p side by side
        rem_a_nxt = rem_step(rem_step(rem_a_r, div_a_r[HASH_W-1], psize_r),
                             div_a_r[HASH_W-2], psize_r);
        rem_b_nxt = rem_step(rem_step(rem_b_r, div_b_r[HASH_W-1], psize_r),
                             div_b_r[HASH_W-2], psize_r);
        rem_c_nxt = rem_step(rem_step(rem_c_r, 1'b1, psize_r), 1'b1, psize_r);
        div_a_nxt = {div_a_r[HASH_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
        div_b_nxt = {div_b_r[HASH_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        r_nxt    = r_cur;
        base_nxt = base_cur;
        if (hi_r != '0) begin
          mixed_nxt = mixed_sum[HASH_W-1:0];
        end
        if (IS_POW2) begin
          addr_nxt  = idx_ext[AW-1:0];
          state_nxt = ST_READ;
        end else begin
          wrap_src_nxt = idx_full;
          wrap_cnt_nxt = WC_W'(1);
          state_nxt    = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (wrap_cnt_r != '0) begin
          // quotient first, remainder the cycle after
          wrap_quot_nxt = IDX_W'(wrap_prod >> RS);
          wrap_cnt_nxt  = wrap_cnt_r - WC_W'(1);
        end else begin
          addr_nxt  = AW'(wrap_left);
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // write lands before the next read is issued, so repeated indexes see it
        case (kind_r)
          KIND_ADD: begin
            if (rd_data_r == COUNTER_MAX) begin
              fault_nxt = FAULT_OVER;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = rd_data_r + CNTR_W'(1);
            end
          end
          KIND_REMOVE: begin
            if (rd_data_r == COUNTER_ZERO) begin
              fault_nxt = FAULT_UNDER;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = rd_data_r - CNTR_W'(1);
            end
          end
          default: begin
            if (rd_data_r == COUNTER_ZERO) begin
              present_nxt = 1'b0;
            end
          end
        endcase
        hi_nxt = hi_r + CW'(1);
        if (hi_r + CW'(1) == nf_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CALC;
        end
      end
      ST_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          case (kind_r)
            KIND_ADD:    item_total_nxt = item_total_r + HASH_W'(1);
            KIND_REMOVE: item_total_nxt = item_total_r - HASH_W'(1);
            default:     item_total_nxt = item_total_r;
          endcase
          out_total_nxt   = item_total_nxt;
          out_present_nxt = present_r;
          out_fault_nxt   = fault_r;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      clr_r            <= '0;
      out_valid_r      <= 1'b0;
      item_total_r     <= '0;
      hash_count_r     <= HC_W'(4);
      partition_size_r <= PS_W'(4096);
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      item_total_r <= item_total_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HASH_COUNT:     hash_count_r     <= cfg_data[HC_W-1:0];
          CFG_PARTITION_SIZE: partition_size_r <= cfg_data[PS_W-1:0];
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    h2_r          <= h2_nxt;
    div_a_r       <= div_a_nxt;
    div_b_r       <= div_b_nxt;
    rem_a_r       <= rem_a_nxt;
    rem_b_r       <= rem_b_nxt;
    rem_c_r       <= rem_c_nxt;
    div_cnt_r     <= div_cnt_nxt;
    psize_r       <= psize_nxt;
    nf_r          <= nf_nxt;
    hi_r          <= hi_nxt;
    mixed_r       <= mixed_nxt;
    r_r           <= r_nxt;
    base_r        <= base_nxt;
    addr_r        <= addr_nxt;
    wrap_src_r    <= wrap_src_nxt;
    wrap_quot_r   <= wrap_quot_nxt;
    wrap_cnt_r    <= wrap_cnt_nxt;
    present_r     <= present_nxt;
    fault_r       <= fault_nxt;
    out_present_r <= out_present_nxt;
    out_fault_r   <= out_fault_nxt;
    out_total_r   <= out_total_nxt;
  end

  // counter memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= store_mem[addr_r];
    end
  end

  // hash slot stays below the clamped count while indexes are formed
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (hi_r < nf_r))
    else $error("hash slot beyond hash count");

  // incremental remainder stays reduced against the partition size
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (r_r < psize_r))
    else $error("partition remainder not reduced");

  // memory address stays inside the store
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> ({1'b0, addr_r} < DEPTH_C))
    else $error("counter address beyond store");

  // the item count moves only when a result is handed over
  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DONE) |=> $stable(item_total_r))
    else $error("item count changed outside result handover");

endmodule

`default_nettype wire
